@@ rtl/core/aarm_pkg.sv @@
// Package for the axis-angle rotation matrix block.
// Holds the work-word type, the cell payload structs, the arctangent table
// and the rounding multiply. No dependencies.
package aarm_pkg;

  localparam int WORK_BITS    = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;
  localparam int CORDIC_STEPS = 30;
  localparam int NSTG         = 1 + SQRT_STEPS + 1 + DIV_STEPS + 5;

  typedef logic signed [33:0] wk_t;

  localparam wk_t CORDIC_GAIN = 34'sd652032874;
  localparam wk_t ONE_Q       = 34'sh040000000;
  localparam wk_t HALF_TURN   = 34'sh080000000;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic [33:0]        rem;
    logic [31:0]        root;
    logic [31:0]        sum;
    logic [15:0]        phase;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } sqrt_cell_t;

  typedef struct packed {
    logic [2:0][61:0] num;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] quo;
    logic [31:0]      rad;
    logic [2:0]       neg;
    logic             zero;
  } div_cell_t;

  typedef struct packed {
    wk_t  x;
    wk_t  y;
    wk_t  z;
    logic flip;
  } cordic_cell_t;

  // Q30 product rounded half away from zero back to Q30.
  function automatic wk_t mulq(input wk_t a, input wk_t b);
    logic signed [67:0] p;
    logic [67:0]        m;
    p = 68'(a) * 68'(b);
    m = p[67] ? 68'(-p) : 68'(p);
    m = (m + (68'd1 << (WORK_BITS - 1))) >> WORK_BITS;
    return p[67] ? wk_t'(-$signed(m[33:0])) : wk_t'($signed(m[33:0]));
  endfunction

endpackage

@@ rtl/core/aarm_in_if.sv @@
// Request channel of the axis-angle rotation matrix block.
// Carries valid, ready and the angle and axis fields. No dependencies.
interface aarm_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        angle_phase;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;

  modport source (output valid, angle_phase, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, angle_phase, axis_x, axis_y, axis_z, output ready);
endinterface

@@ rtl/core/aarm_out_if.sv @@
// Result channel of the axis-angle rotation matrix block.
// Carries valid, ready, the nine matrix entries and the zero-axis flag.
interface aarm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] c0_r0;
  logic signed [15:0] c0_r1;
  logic signed [15:0] c0_r2;
  logic signed [15:0] c1_r0;
  logic signed [15:0] c1_r1;
  logic signed [15:0] c1_r2;
  logic signed [15:0] c2_r0;
  logic signed [15:0] c2_r1;
  logic signed [15:0] c2_r2;
  logic               axis_was_zero;

  modport source (output valid, c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2,
                  c2_r0, c2_r1, c2_r2, axis_was_zero, input ready);
  modport sink   (input valid, c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2,
                  c2_r0, c2_r1, c2_r2, axis_was_zero, output ready);
endinterface

@@ rtl/core/aarm_sqrt_cell.sv @@
// One cell of the square root chain: resolves one root bit per cycle while enabled.
// Depends on aarm_pkg.
module aarm_sqrt_cell
  import aarm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       en,
  input  sqrt_cell_t din,
  output sqrt_cell_t dout
);

  sqrt_cell_t  dout_r, dout_nxt;
  logic [1:0]  pair;
  logic [34:0] rem2;
  logic [34:0] trial;

  generate
    if (IDX < 16) begin : g_hi
      assign pair = din.sum[31 - 2 * IDX -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end
  endgenerate

  always_comb begin
    dout_nxt = din;
    rem2     = {din.rem[32:0], pair};
    trial    = {1'b0, din.root, 2'b01};
    if (rem2 >= trial) begin
      dout_nxt.rem  = 34'(rem2 - trial);
      dout_nxt.root = {din.root[30:0], 1'b1};
    end else begin
      dout_nxt.rem  = 34'(rem2);
      dout_nxt.root = {din.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

@@ rtl/core/aarm_div_cell.sv @@
// One cell of the normalizing divider chain: one quotient bit per cycle
// for each of the three axis components while enabled. Depends on aarm_pkg.
module aarm_div_cell
  import aarm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      en,
  input  div_cell_t din,
  output div_cell_t dout
);

  div_cell_t   dout_r, dout_nxt;
  logic [32:0] rem2;

  always_comb begin
    dout_nxt = din;
    rem2     = '0;
    for (int k = 0; k < 3; k++) begin
      rem2 = {din.rem[k], din.num[k][DIV_STEPS - 1 - IDX]};
      if (rem2 >= {1'b0, din.rad}) begin
        dout_nxt.rem[k] = 32'(rem2 - {1'b0, din.rad});
        dout_nxt.quo[k] = {din.quo[k][29:0], 1'b1};
      end else begin
        dout_nxt.rem[k] = rem2[31:0];
        dout_nxt.quo[k] = {din.quo[k][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

@@ rtl/core/aarm_cordic_cell.sv @@
// One cell of the CORDIC rotator chain: one micro-rotation per cycle while enabled.
// Depends on aarm_pkg.
module aarm_cordic_cell
  import aarm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic         clk,
  input  logic         en,
  input  cordic_cell_t din,
  output cordic_cell_t dout
);

  localparam wk_t ATAN = wk_t'({2'b00, ATAN_TURNS[IDX]});

  cordic_cell_t dout_r, dout_nxt;

  always_comb begin
    dout_nxt = din;
    if (!din.z[33]) begin
      dout_nxt.x = din.x - (din.y >>> IDX);
      dout_nxt.y = din.y + (din.x >>> IDX);
      dout_nxt.z = din.z - ATAN;
    end else begin
      dout_nxt.x = din.x + (din.y >>> IDX);
      dout_nxt.y = din.y - (din.x >>> IDX);
      dout_nxt.z = din.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

@@ rtl/core/axis_angle_rotation_matrix_top.sv @@
// Axis-angle rotation matrix: a fully pipelined Rodrigues rotation builder
// that takes one request per cycle unless a held result stalls it, most of
// its pipeline being the 32-cell square root chain and the 31-cell divider
// chain that normalize the axis (the 30-cell CORDIC chain runs beside the
// divider). When a result is not taken, the whole pipeline holds and the
// request side stalls. Depends on aarm_pkg, aarm_in_if, aarm_out_if and the
// three cell modules.
module axis_angle_rotation_matrix_top
  import aarm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  aarm_in_if.sink    in_req,
  aarm_out_if.source out_res
);

  localparam int          SH     = WORK_BITS - FRAC_BITS;
  localparam logic [33:0] RHALF  = (34'd1 << SH) >> 1;
  localparam logic [33:0] ONE_O  = 34'd1 << FRAC_BITS;

  logic            en;
  logic [NSTG-1:0] vld_r;

  sqrt_cell_t   sq [SQRT_STEPS + 1];
  div_cell_t    dv [DIV_STEPS + 1];
  cordic_cell_t cr [CORDIC_STEPS + 1];

  sqrt_cell_t   sq0_r, sq0_nxt;
  div_cell_t    dv0_r, dv0_nxt;
  cordic_cell_t cr0_r, cr0_nxt;

  wk_t  cp_c_r, cp_s_r, cp_t_r;
  wk_t  u_r [3];
  wk_t  m1_c_r, m1_s_r, m1_t_r;
  logic m1_zero_r;
  wk_t  p_r [6];
  wk_t  su_r [3];
  wk_t  m2_c_r, m2_t_r;
  logic m2_zero_r;
  wk_t  tq_r [6];
  wk_t  m3_su_r [3];
  wk_t  m3_c_r;
  logic m3_zero_r;
  wk_t  e_r [9];
  logic m4_zero_r;
  logic [15:0] o_r [9];
  logic        o_zero_r;

  logic [31:0] px, py, pz;

  assign en           = !vld_r[NSTG-1] || out_res.ready;
  assign in_req.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_req.valid};
    end
  end

  always_comb begin
    px = 32'(32'(in_req.axis_x) * 32'(in_req.axis_x));
    py = 32'(32'(in_req.axis_y) * 32'(in_req.axis_y));
    pz = 32'(32'(in_req.axis_z) * 32'(in_req.axis_z));
    sq0_nxt       = '0;
    sq0_nxt.sum   = px + py + pz;
    sq0_nxt.phase = in_req.angle_phase;
    sq0_nxt.ax    = in_req.axis_x;
    sq0_nxt.ay    = in_req.axis_y;
    sq0_nxt.az    = in_req.axis_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r <= sq0_nxt;
    end
  end

  assign sq[0] = sq0_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    aarm_sqrt_cell #(.IDX(i)) u_cell (
      .clk(clk), .en(en), .din(sq[i]), .dout(sq[i+1])
    );
  end

  always_comb begin
    logic signed [15:0] a [3];
    logic [15:0]        mag;
    logic [31:0]        ang;
    wk_t                z;
    a[0] = sq[SQRT_STEPS].ax;
    a[1] = sq[SQRT_STEPS].ay;
    a[2] = sq[SQRT_STEPS].az;
    dv0_nxt      = '0;
    dv0_nxt.rad  = sq[SQRT_STEPS].root;
    dv0_nxt.zero = sq[SQRT_STEPS].sum == 32'd0;
    for (int k = 0; k < 3; k++) begin
      dv0_nxt.neg[k] = a[k][15];
      mag            = a[k][15] ? 16'(-a[k]) : 16'(a[k]);
      dv0_nxt.num[k] = {mag, 46'd0} + 62'(sq[SQRT_STEPS].root[31:1]);
      dv0_nxt.rem[k] = 32'(dv0_nxt.num[k][61:31]);
    end
    ang          = {sq[SQRT_STEPS].phase, 16'd0};
    z            = wk_t'({{2{ang[31]}}, ang});
    cr0_nxt.x    = CORDIC_GAIN;
    cr0_nxt.y    = '0;
    cr0_nxt.flip = 1'b0;
    if (z > ONE_Q) begin
      z            = z - HALF_TURN;
      cr0_nxt.flip = 1'b1;
    end else if (z < -ONE_Q) begin
      z            = z + HALF_TURN;
      cr0_nxt.flip = 1'b1;
    end
    cr0_nxt.z = z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv0_r <= dv0_nxt;
      cr0_r <= cr0_nxt;
    end
  end

  assign dv[0] = dv0_r;
  assign cr[0] = cr0_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    aarm_div_cell #(.IDX(i)) u_cell (
      .clk(clk), .en(en), .din(dv[i]), .dout(dv[i+1])
    );
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    aarm_cordic_cell #(.IDX(i)) u_cell (
      .clk(clk), .en(en), .din(cr[i]), .dout(cr[i+1])
    );
  end

  // The CORDIC chain is one cell shorter than the divider, so the sign
  // fold-back gets a register of its own to line the two up.
  always_ff @(posedge clk) begin
    if (en) begin
      cp_c_r <= cr[CORDIC_STEPS].flip ? -cr[CORDIC_STEPS].x : cr[CORDIC_STEPS].x;
      cp_s_r <= cr[CORDIC_STEPS].flip ? -cr[CORDIC_STEPS].y : cr[CORDIC_STEPS].y;
      cp_t_r <= cr[CORDIC_STEPS].flip ? ONE_Q + cr[CORDIC_STEPS].x
                                      : ONE_Q - cr[CORDIC_STEPS].x;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_r[k] <= dv[DIV_STEPS].neg[k] ? -wk_t'({3'b000, dv[DIV_STEPS].quo[k]})
                                       : wk_t'({3'b000, dv[DIV_STEPS].quo[k]});
      end
      m1_c_r    <= cp_c_r;
      m1_s_r    <= cp_s_r;
      m1_t_r    <= cp_t_r;
      m1_zero_r <= dv[DIV_STEPS].zero;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= mulq(u_r[0], u_r[0]);
      p_r[1] <= mulq(u_r[1], u_r[1]);
      p_r[2] <= mulq(u_r[2], u_r[2]);
      p_r[3] <= mulq(u_r[0], u_r[1]);
      p_r[4] <= mulq(u_r[0], u_r[2]);
      p_r[5] <= mulq(u_r[1], u_r[2]);
      for (int k = 0; k < 3; k++) begin
        su_r[k] <= mulq(u_r[k], m1_s_r);
      end
      m2_c_r    <= m1_c_r;
      m2_t_r    <= m1_t_r;
      m2_zero_r <= m1_zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        tq_r[k] <= mulq(m2_t_r, p_r[k]);
      end
      m3_su_r   <= su_r;
      m3_c_r    <= m2_c_r;
      m3_zero_r <= m2_zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (m3_zero_r) begin
        for (int k = 0; k < 9; k++) begin
          e_r[k] <= (k == 0 || k == 4 || k == 8) ? ONE_Q : '0;
        end
      end else begin
        e_r[0] <= m3_c_r + tq_r[0];
        e_r[1] <= tq_r[3] + m3_su_r[2];
        e_r[2] <= tq_r[4] - m3_su_r[1];
        e_r[3] <= tq_r[3] - m3_su_r[2];
        e_r[4] <= m3_c_r + tq_r[1];
        e_r[5] <= tq_r[5] + m3_su_r[0];
        e_r[6] <= tq_r[4] + m3_su_r[1];
        e_r[7] <= tq_r[5] - m3_su_r[0];
        e_r[8] <= m3_c_r + tq_r[2];
      end
      m4_zero_r <= m3_zero_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [33:0] mag;
    logic [33:0] rm;
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        mag = e_r[k][33] ? 34'(-e_r[k]) : 34'(e_r[k]);
        rm  = (mag + RHALF) >> SH;
        if (rm > ONE_O) begin
          rm = ONE_O;
        end
        o_r[k] <= e_r[k][33] ? 16'(-rm) : rm[15:0];
      end
      o_zero_r <= m4_zero_r;
    end
  end

  assign out_res.valid         = vld_r[NSTG-1];
  assign out_res.c0_r0         = o_r[0];
  assign out_res.c0_r1         = o_r[1];
  assign out_res.c0_r2         = o_r[2];
  assign out_res.c1_r0         = o_r[3];
  assign out_res.c1_r1         = o_r[4];
  assign out_res.c1_r2         = o_r[5];
  assign out_res.c2_r0         = o_r[6];
  assign out_res.c2_r1         = o_r[7];
  assign out_res.c2_r2         = o_r[8];
  assign out_res.axis_was_zero = o_zero_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |-> !in_req.ready)
    else $error("Request side open while a result is held.");

  a_zero_off_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.axis_was_zero |->
      out_res.c0_r1 == 16'd0 && out_res.c0_r2 == 16'd0 &&
      out_res.c1_r0 == 16'd0 && out_res.c1_r2 == 16'd0 &&
      out_res.c2_r0 == 16'd0 && out_res.c2_r1 == 16'd0)
    else $error("Zero axis result has off-diagonal entries.");

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQRT_STEPS] |->
      (66'(sq[SQRT_STEPS].root) * 66'(sq[SQRT_STEPS].root)
         <= 66'({sq[SQRT_STEPS].sum, 32'd0})) &&
      ((66'(sq[SQRT_STEPS].root) + 66'd1) * (66'(sq[SQRT_STEPS].root) + 66'd1)
         > 66'({sq[SQRT_STEPS].sum, 32'd0})))
    else $error("Square root chain result is not the floor root.");

endmodule

@@ tb/tb_aarm_if.sv @@
// Testbench-side note: the channel interfaces come from the RTL files
// aarm_in_if.sv and aarm_out_if.sv; this file holds a small parameter package.
// Depends on nothing.
`timescale 1ns / 1ps
package tb_aarm_pkg;
  localparam int TB_FRAC_BITS = 14;
endpackage

@@ tb/aarm_checker.sv @@
// Checker for the axis-angle rotation matrix block: predicts each matrix
// from the request transfers and compares every result transfer in order.
// Depends on aarm_pkg, aarm_in_if, aarm_out_if and tb_aarm_pkg.
`timescale 1ns / 1ps
module aarm_checker
  import aarm_pkg::*;
  import tb_aarm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  aarm_in_if         req,
  aarm_out_if        res,
  output int         fail_count,
  output int         pending
);
  typedef struct {
    logic [15:0] e[9];
    logic        zero;
  } matrix_t;

  matrix_t expected_q[$];

  function automatic longint asr_fl(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    longint m;
    if (s == 0) return v;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 << (s - 1))) >> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shift(a * b, WORK_BITS);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unit_comp(longint a, longint unsigned r);
    longint unsigned m;
    m = (a < 0) ? -a : a;
    m = ((m << 46) + (r >> 1)) / r;
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [15:0] to_entry(longint v);
    longint one;
    one = 64'sd1 << TB_FRAC_BITS;
    v = rnd_shift(v, WORK_BITS - TB_FRAC_BITS);
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[15:0];
  endfunction

  function automatic matrix_t rotation_matrix(logic [15:0] ph, logic signed [15:0] ax,
                                              logic signed [15:0] ay, logic signed [15:0] az);
    matrix_t m;
    longint x, y, z, nx, c, s, t, ux, uy, uz;
    longint e[9];
    longint unsigned sum, r;
    logic flip;
    sum = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
    if (sum == 0) begin
      foreach (m.e[k]) m.e[k] = (k % 4 == 0) ? 16'(1 << TB_FRAC_BITS) : 16'd0;
      m.zero = 1'b1;
      return m;
    end
    r = int_sqrt(sum << 32);
    ux = unit_comp(ax, r);
    uy = unit_comp(ay, r);
    uz = unit_comp(az, r);
    z = longint'($signed({ph, 16'd0}));
    flip = 1'b0;
    if (z > (64'sd1 << 30)) begin
      z -= 64'sd1 << 31;
      flip = 1'b1;
    end else if (z < -(64'sd1 << 30)) begin
      z += 64'sd1 << 31;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - asr_fl(y, i);
        y = y + asr_fl(x, i);
        z -= longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + asr_fl(y, i);
        y = y - asr_fl(x, i);
        z += longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = (64'sd1 << WORK_BITS) - c;
    e[0] = c + qmul(t, qmul(ux, ux));
    e[1] = qmul(t, qmul(ux, uy)) + qmul(uz, s);
    e[2] = qmul(t, qmul(ux, uz)) - qmul(uy, s);
    e[3] = qmul(t, qmul(ux, uy)) - qmul(uz, s);
    e[4] = c + qmul(t, qmul(uy, uy));
    e[5] = qmul(t, qmul(uy, uz)) + qmul(ux, s);
    e[6] = qmul(t, qmul(ux, uz)) + qmul(uy, s);
    e[7] = qmul(t, qmul(uy, uz)) - qmul(ux, s);
    e[8] = c + qmul(t, qmul(uz, uz));
    foreach (m.e[k]) m.e[k] = to_entry(e[k]);
    m.zero = 1'b0;
    return m;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    matrix_t want;
    logic [15:0] got[9];
    int errs;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      errs = 0;
      if (req.valid && req.ready)
        expected_q.push_back(rotation_matrix(req.angle_phase, req.axis_x, req.axis_y,
                                             req.axis_z));
      if (res.valid && res.ready) begin
        got = '{res.c0_r0, res.c0_r1, res.c0_r2, res.c1_r0, res.c1_r1, res.c1_r2,
                res.c2_r0, res.c2_r1, res.c2_r2};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer", $time);
          errs = errs + 1;
        end else begin
          want = expected_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k] !== want.e[k]) begin
              $display("%0t: entry c%0d_r%0d expected %0d got %0d", $time, k / 3, k % 3,
                       $signed(want.e[k]), $signed(got[k]));
              errs = errs + 1;
            end
          if (res.axis_was_zero !== want.zero) begin
            $display("%0t: axis_was_zero expected %0b got %0b", $time, want.zero,
                     res.axis_was_zero);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

@@ tb/tb.sv @@
// Top of the rotation matrix testbench: drives directed and random
// requests with random idling and gives the verdict.
// Depends on aarm_pkg, the channel interfaces, aarm_checker and the block.
`timescale 1ns / 1ps
module tb;
  import aarm_pkg::*;

  localparam int LATENCY = 70;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   send_idle = 31;
  int   take_idle = 76;

  aarm_in_if  req ();
  aarm_out_if res ();

  axis_angle_rotation_matrix_top dut (.clk(clk), .rst_n(rst_n), .in_req(req), .out_res(res));
  aarm_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .res(res),
                    .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk)
    res.ready <= rst_n && ($urandom_range(99) >= take_idle);

  task automatic send_request(logic [15:0] ph, logic [15:0] ax, logic [15:0] ay,
                              logic [15:0] az);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.angle_phase <= ph;
    req.axis_x <= ax;
    req.axis_y <= ay;
    req.axis_z <= az;
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(4))
      0: return 16'($urandom_range(7)) - 16'd3;
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] phases[10] = '{16'h0000, 16'h4000, 16'h4001, 16'h8000, 16'hc000,
                                16'hbfff, 16'hffff, 16'h2000, 16'h0001, 16'h7fff};
    req.valid = 1'b0;
    req.angle_phase = '0;
    req.axis_x = '0;
    req.axis_y = '0;
    req.axis_z = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (phases[i]) send_request(phases[i], 16'h0000, 16'h0000, 16'h0000);
    send_request(16'h1234, 16'h7fff, 16'h0000, 16'h0000);
    send_request(16'h5678, 16'h0000, 16'h8000, 16'h0000);
    send_request(16'h9abc, 16'h0000, 16'h0000, 16'h7fff);
    send_request(16'hffff, 16'h8000, 16'h8000, 16'h8000);
    send_request(16'h4000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(16'h8000, 16'h0001, 16'hffff, 16'h0001);
    send_request(16'h2aaa, 16'h8000, 16'h7fff, 16'h0001);
    send_request(16'hc000, 16'h0003, 16'h0004, 16'h0000);
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int phase_sel = 0; phase_sel < 3; phase_sel++) begin
      send_idle = (phase_sel == 0) ? 31 : (phase_sel == 1) ? 76 : 0;
      take_idle = (phase_sel == 0) ? 76 : (phase_sel == 1) ? 31 : 0;
      for (int n = 0; n < 580; n++)
        send_request(16'($urandom), rand_comp(), rand_comp(), rand_comp());
    end
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/aarm_pkg.sv
rtl/core/aarm_in_if.sv
rtl/core/aarm_out_if.sv
rtl/core/aarm_sqrt_cell.sv
rtl/core/aarm_div_cell.sv
rtl/core/aarm_cordic_cell.sv
rtl/core/axis_angle_rotation_matrix_top.sv
tb/tb_aarm_if.sv
tb/aarm_checker.sv
tb/tb.sv
